// ===== rtl/cbercu_pkg.sv =====
package cbercu_pkg;

   localparam int CNT_W     = 9;
   localparam int WIN_W     = 10;
   localparam int ACC_W     = 20;
   localparam int CLASS_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [CLASS_W-1:0] CLASS_1A   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_1B   = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_2    = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_LOST_1A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOST_1B   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOST_2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_ONES  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REPORT_LEN = 3'd4;

   localparam logic [CNT_W-1:0] RST_LOST_1A   = 9'd50;
   localparam logic [CNT_W-1:0] RST_LOST_1B   = 9'd132;
   localparam logic [CNT_W-1:0] RST_LOST_2    = 9'd78;
   localparam logic [CNT_W-1:0] RST_MIN_ONES  = 9'd32;
   localparam logic [WIN_W-1:0] RST_REPORT_LEN = 10'd200;

   typedef struct packed {
      logic             lost;
      logic             ignored;
      logic [CNT_W-1:0] err_1a;
      logic [CNT_W-1:0] err_1b;
      logic [CNT_W-1:0] err_2;
   } frame_rec_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] val, input logic inc);
      logic [CNT_W-1:0] res;
      res = val;
      if (inc && (val != {CNT_W{1'b1}})) begin
         res = val + CNT_W'(1);
      end
      return res;
   endfunction

endpackage

// ===== rtl/cbercu_front.sv =====
module cbercu_front
   import cbercu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic               req_rx_bit,
   input  logic               req_ref_bit,
   input  logic [CLASS_W-1:0] req_bit_class,
   input  logic               req_last_bit,
   input  logic [CNT_W-1:0]   lost_1a,
   input  logic [CNT_W-1:0]   lost_1b,
   input  logic [CNT_W-1:0]   lost_2,
   input  logic [CNT_W-1:0]   min_ones,
   input  logic               queue_full,
   output logic               push,
   output frame_rec_type      push_rec
);

   logic [CNT_W-1:0] err_1a_ff, err_1a_in;
   logic [CNT_W-1:0] err_1b_ff, err_1b_in;
   logic [CNT_W-1:0] err_2_ff, err_2_in;
   logic [CNT_W-1:0] ones_ff, ones_in;
   logic [CNT_W-1:0] err_1a_upd, err_1b_upd, err_2_upd, ones_upd;
   logic             accept;
   logic             bit_err;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign bit_err   = req_rx_bit ^ req_ref_bit;

   always_comb begin
      err_1a_upd = err_1a_ff;
      err_1b_upd = err_1b_ff;
      err_2_upd  = err_2_ff;
      ones_upd   = ones_ff;
      case (req_bit_class)
         CLASS_1A: begin
            err_1a_upd = sat_inc(err_1a_ff, bit_err);
            ones_upd   = sat_inc(ones_ff, req_rx_bit);
         end
         CLASS_1B: begin
            err_1b_upd = sat_inc(err_1b_ff, bit_err);
            ones_upd   = sat_inc(ones_ff, req_rx_bit);
         end
         CLASS_2: begin
            err_2_upd = sat_inc(err_2_ff, bit_err);
            ones_upd  = sat_inc(ones_ff, req_rx_bit);
         end
         CLASS_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      err_1a_in = err_1a_ff;
      err_1b_in = err_1b_ff;
      err_2_in  = err_2_ff;
      ones_in   = ones_ff;
      push      = 1'b0;
      push_rec.lost    = req_func;
      push_rec.ignored = 1'b0;
      push_rec.err_1a  = err_1a_upd;
      push_rec.err_1b  = err_1b_upd;
      push_rec.err_2   = err_2_upd;
      if (req_func) begin
         push_rec.err_1a = lost_1a >> 1;
         push_rec.err_1b = lost_1b >> 1;
         push_rec.err_2  = lost_2 >> 1;
         push = accept;
      end else if (accept) begin
         if (req_last_bit) begin
            push             = 1'b1;
            push_rec.ignored = ones_upd < min_ones;
            err_1a_in        = '0;
            err_1b_in        = '0;
            err_2_in         = '0;
            ones_in          = '0;
         end else begin
            err_1a_in = err_1a_upd;
            err_1b_in = err_1b_upd;
            err_2_in  = err_2_upd;
            ones_in   = ones_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_1a_ff <= '0;
         err_1b_ff <= '0;
         err_2_ff  <= '0;
         ones_ff   <= '0;
      end else begin
         err_1a_ff <= err_1a_in;
         err_1b_ff <= err_1b_in;
         err_2_ff  <= err_2_in;
         ones_ff   <= ones_in;
      end
   end

endmodule

// ===== rtl/cbercu_queue.sv =====
module cbercu_queue
   import cbercu_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frame_rec_type push_rec,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output frame_rec_type head_rec
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   frame_rec_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;

   assign full      = count_ff == CNT_QW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head_rec  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ===== rtl/cbercu_back.sv =====
module cbercu_back
   import cbercu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rec_valid,
   input  frame_rec_type    rec,
   output logic             pop,
   input  logic [WIN_W-1:0] report_length,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_frame_bad,
   output logic             rsp_frame_ignored,
   output logic [CNT_W-1:0] rsp_frame_class1a_errors,
   output logic [CNT_W-1:0] rsp_frame_class1b_errors,
   output logic [CNT_W-1:0] rsp_frame_class2_errors,
   output logic             rsp_measuring,
   output logic             rsp_report_ready,
   output logic [WIN_W-1:0] rsp_report_frame_errors,
   output logic [ACC_W-1:0] rsp_report_class1b_errors,
   output logic [ACC_W-1:0] rsp_report_class2_errors
);

   logic             valid_ff, valid_in;
   logic             running_ff, running_in;
   logic [WIN_W-1:0] frames_ff, frames_in;
   logic [WIN_W-1:0] acc_fe_ff, acc_fe_in;
   logic [ACC_W-1:0] acc_1b_ff, acc_1b_in;
   logic [ACC_W-1:0] acc_2_ff, acc_2_in;

   logic             bad_ff, ignored_ff, meas_ff, rep_ff;
   logic [CNT_W-1:0] e1a_ff, e1b_ff, e2_ff;
   logic [WIN_W-1:0] rep_fe_ff, rep_fe_in;
   logic [ACC_W-1:0] rep_1b_ff, rep_1b_in;
   logic [ACC_W-1:0] rep_2_ff, rep_2_in;
   logic             rep_in;

   logic             counted;
   logic             has_1a;
   logic [ACC_W:0]   sum_1b, sum_2;
   logic [WIN_W-1:0] fe_upd, frames_upd;
   logic [ACC_W-1:0] acc_1b_upd, acc_2_upd;

   assign pop     = rec_valid && (!valid_ff || rsp_ready);
   assign has_1a  = rec.err_1a != '0;
   assign counted = !rec.ignored && running_ff;
   assign sum_1b  = {1'b0, acc_1b_ff} + (ACC_W+1)'(rec.err_1b);
   assign sum_2   = {1'b0, acc_2_ff} + (ACC_W+1)'(rec.err_2);

   always_comb begin
      fe_upd     = acc_fe_ff;
      if (has_1a && (acc_fe_ff != {WIN_W{1'b1}})) begin
         fe_upd = acc_fe_ff + WIN_W'(1);
      end
      acc_1b_upd = sum_1b[ACC_W] ? {ACC_W{1'b1}} : sum_1b[ACC_W-1:0];
      acc_2_upd  = sum_2[ACC_W] ? {ACC_W{1'b1}} : sum_2[ACC_W-1:0];
      frames_upd = frames_ff + WIN_W'(1);

      running_in = running_ff;
      frames_in  = frames_ff;
      acc_fe_in  = acc_fe_ff;
      acc_1b_in  = acc_1b_ff;
      acc_2_in   = acc_2_ff;
      rep_in     = 1'b0;
      rep_fe_in  = '0;
      rep_1b_in  = '0;
      rep_2_in   = '0;
      valid_in   = valid_ff && !rsp_ready;

      if (pop) begin
         valid_in = 1'b1;
         if (counted) begin
            if (frames_upd == report_length) begin
               rep_in    = 1'b1;
               rep_fe_in = fe_upd;
               rep_1b_in = acc_1b_upd;
               rep_2_in  = acc_2_upd;
               frames_in = '0;
               acc_fe_in = '0;
               acc_1b_in = '0;
               acc_2_in  = '0;
            end else begin
               frames_in = frames_upd;
               acc_fe_in = fe_upd;
               acc_1b_in = acc_1b_upd;
               acc_2_in  = acc_2_upd;
            end
         end
         if (!rec.lost && !rec.ignored && !has_1a) begin
            running_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         running_ff <= 1'b0;
         frames_ff  <= '0;
         acc_fe_ff  <= '0;
         acc_1b_ff  <= '0;
         acc_2_ff   <= '0;
      end else begin
         valid_ff   <= valid_in;
         running_ff <= running_in;
         frames_ff  <= frames_in;
         acc_fe_ff  <= acc_fe_in;
         acc_1b_ff  <= acc_1b_in;
         acc_2_ff   <= acc_2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         bad_ff     <= rec.ignored || has_1a;
         ignored_ff <= rec.ignored;
         e1a_ff     <= rec.err_1a;
         e1b_ff     <= rec.err_1b;
         e2_ff      <= rec.err_2;
         meas_ff    <= running_in;
         rep_ff     <= rep_in;
         rep_fe_ff  <= rep_fe_in;
         rep_1b_ff  <= rep_1b_in;
         rep_2_ff   <= rep_2_in;
      end
   end

   assign rsp_valid                 = valid_ff;
   assign rsp_frame_bad             = bad_ff;
   assign rsp_frame_ignored         = ignored_ff;
   assign rsp_frame_class1a_errors  = e1a_ff;
   assign rsp_frame_class1b_errors  = e1b_ff;
   assign rsp_frame_class2_errors   = e2_ff;
   assign rsp_measuring             = meas_ff;
   assign rsp_report_ready          = rep_ff;
   assign rsp_report_frame_errors   = rep_fe_ff;
   assign rsp_report_class1b_errors = rep_1b_ff;
   assign rsp_report_class2_errors  = rep_2_ff;

endmodule

// ===== rtl/classified_bit_error_rate_counter_unit.sv =====
// Classified bit error counter for received speech frames.
// Input channel (req_): one word per received bit with its reference bit,
// protection class and end-of-frame mark, or one word for a whole lost frame
// (req_func high). Words are taken back to back, one per cycle, while req_ready is high.
// Result channel (rsp_): one word per finished or lost frame with the frame's
// per-class error counts, bad/ignored flags, measuring state and, at the end
// of each window, the accumulated report. Words without a frame end give none.
// A frame's result passes through the queue and then the result register,
// and waits in the queue while the receiver stalls. Throughput: one word
// per cycle on both sides while the queue has room and the receiver is
// ready, set by the front's frame counters and the back's accumulator.
// A four-entry queue decouples the front from the result register: when the
// receiver stalls, results pile up in the queue and req_ready drops only
// once the queue is full.
// Configuration (csr_): index and data, always ready; write only while idle.
// Reset clears all counters, the queue and the measuring state, and loads
// the register defaults; measuring starts after the first clean frame.
module classified_bit_error_rate_counter_unit
   import cbercu_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic                 req_rx_bit,
   input  logic                 req_ref_bit,
   input  logic [CLASS_W-1:0]   req_bit_class,
   input  logic                 req_last_bit,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_frame_bad,
   output logic                 rsp_frame_ignored,
   output logic [CNT_W-1:0]     rsp_frame_class1a_errors,
   output logic [CNT_W-1:0]     rsp_frame_class1b_errors,
   output logic [CNT_W-1:0]     rsp_frame_class2_errors,
   output logic                 rsp_measuring,
   output logic                 rsp_report_ready,
   output logic [WIN_W-1:0]     rsp_report_frame_errors,
   output logic [ACC_W-1:0]     rsp_report_class1b_errors,
   output logic [ACC_W-1:0]     rsp_report_class2_errors,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   logic [CNT_W-1:0] lost_1a_ff, lost_1b_ff, lost_2_ff, min_ones_ff;
   logic [WIN_W-1:0] report_len_ff;
   logic             csr_write;

   logic             queue_full, push, pop, rec_valid;
   frame_rec_type    push_rec, head_rec;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lost_1a_ff    <= RST_LOST_1A;
         lost_1b_ff    <= RST_LOST_1B;
         lost_2_ff     <= RST_LOST_2;
         min_ones_ff   <= RST_MIN_ONES;
         report_len_ff <= RST_REPORT_LEN;
      end else if (csr_write) begin
         case (csr_index)
            REG_LOST_1A:    lost_1a_ff    <= csr_wdata[CNT_W-1:0];
            REG_LOST_1B:    lost_1b_ff    <= csr_wdata[CNT_W-1:0];
            REG_LOST_2:     lost_2_ff     <= csr_wdata[CNT_W-1:0];
            REG_MIN_ONES:   min_ones_ff   <= csr_wdata[CNT_W-1:0];
            REG_REPORT_LEN: report_len_ff <= csr_wdata[WIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cbercu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_rx_bit    (req_rx_bit),
      .req_ref_bit   (req_ref_bit),
      .req_bit_class (req_bit_class),
      .req_last_bit  (req_last_bit),
      .lost_1a       (lost_1a_ff),
      .lost_1b       (lost_1b_ff),
      .lost_2        (lost_2_ff),
      .min_ones      (min_ones_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_rec      (push_rec)
   );

   cbercu_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (rec_valid),
      .head_rec  (head_rec)
   );

   cbercu_back u_back (
      .clock                     (clock),
      .reset                     (reset),
      .rec_valid                 (rec_valid),
      .rec                       (head_rec),
      .pop                       (pop),
      .report_length             (report_len_ff),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_frame_bad             (rsp_frame_bad),
      .rsp_frame_ignored         (rsp_frame_ignored),
      .rsp_frame_class1a_errors  (rsp_frame_class1a_errors),
      .rsp_frame_class1b_errors  (rsp_frame_class1b_errors),
      .rsp_frame_class2_errors   (rsp_frame_class2_errors),
      .rsp_measuring             (rsp_measuring),
      .rsp_report_ready          (rsp_report_ready),
      .rsp_report_frame_errors   (rsp_report_frame_errors),
      .rsp_report_class1b_errors (rsp_report_class1b_errors),
      .rsp_report_class2_errors  (rsp_report_class2_errors)
   );

endmodule

// ===== rtl/cbercu_checker.sv =====
module cbercu_checker
   import cbercu_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_frame_bad,
   input logic                 rsp_frame_ignored,
   input logic [CNT_W-1:0]     rsp_frame_class1a_errors,
   input logic                 rsp_measuring,
   input logic                 rsp_report_ready,
   input logic [WIN_W-1:0]     rsp_report_frame_errors,
   input logic [ACC_W-1:0]     rsp_report_class1b_errors,
   input logic [ACC_W-1:0]     rsp_report_class2_errors
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_bad_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_bad == (rsp_frame_ignored || (rsp_frame_class1a_errors != '0))))
      else $error("frame_bad disagrees with ignored flag and class 1a count");

   a_report_measuring: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_ready |-> rsp_measuring && !rsp_frame_ignored)
      else $error("report issued outside measurement");

   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_ready |-> rsp_report_frame_errors == '0
         && rsp_report_class1b_errors == '0 && rsp_report_class2_errors == '0)
      else $error("report fields nonzero without a report");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind classified_bit_error_rate_counter_unit cbercu_checker u_checker (.*);

// ===== dv/classified_bit_error_rate_counter_unit_tb.sv =====
module classified_bit_error_rate_counter_unit_tb
   import cbercu_pkg::*;
();

   localparam int MAX_CNT = (1 << CNT_W) - 1;
   localparam int MAX_WIN = (1 << WIN_W) - 1;
   localparam int MAX_ACC = (1 << ACC_W) - 1;
   localparam int IDLE_PCT = 37;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_WORDS = 780;
   localparam int PHASE_WORDS = 130;
   localparam int SAT_FRAME_BITS = 520;

   typedef struct {
      logic               frame_bad;
      logic               frame_ignored;
      logic [CNT_W-1:0]   err_1a;
      logic [CNT_W-1:0]   err_1b;
      logic [CNT_W-1:0]   err_2;
      logic               measuring;
      logic               report_ready;
      logic [WIN_W-1:0]   report_frame_errors;
      logic [ACC_W-1:0]   report_1b;
      logic [ACC_W-1:0]   report_2;
   } frame_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_func = 1'b0;
   logic                 req_rx_bit = 1'b0;
   logic                 req_ref_bit = 1'b0;
   logic [CLASS_W-1:0]   req_bit_class = CLASS_1A;
   logic                 req_last_bit = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_frame_bad;
   logic                 rsp_frame_ignored;
   logic [CNT_W-1:0]     rsp_frame_class1a_errors;
   logic [CNT_W-1:0]     rsp_frame_class1b_errors;
   logic [CNT_W-1:0]     rsp_frame_class2_errors;
   logic                 rsp_measuring;
   logic                 rsp_report_ready;
   logic [WIN_W-1:0]     rsp_report_frame_errors;
   logic [ACC_W-1:0]     rsp_report_class1b_errors;
   logic [ACC_W-1:0]     rsp_report_class2_errors;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_LOST_1A;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // predictor copy of registers and counters
   logic [CNT_W-1:0]     cfg_lost_1a, cfg_lost_1b, cfg_lost_2, cfg_min_ones;
   logic [WIN_W-1:0]     cfg_report_len;
   logic [CNT_W-1:0]     frame_err_1a, frame_err_1b, frame_err_2, frame_ones;
   logic                 measuring_mode;
   logic [WIN_W-1:0]     window_count, win_frame_errors;
   logic [ACC_W-1:0]     win_err_1b, win_err_2;

   frame_result_type     expected_frames_q[$];
   int                   error_count = 0;
   int                   words_sent = 0;
   bit                   no_idle = 1'b0;
   bit                   hold_off_req = 1'b0;

   classified_bit_error_rate_counter_unit u_dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_func                  (req_func),
      .req_rx_bit                (req_rx_bit),
      .req_ref_bit               (req_ref_bit),
      .req_bit_class             (req_bit_class),
      .req_last_bit              (req_last_bit),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_frame_bad             (rsp_frame_bad),
      .rsp_frame_ignored         (rsp_frame_ignored),
      .rsp_frame_class1a_errors  (rsp_frame_class1a_errors),
      .rsp_frame_class1b_errors  (rsp_frame_class1b_errors),
      .rsp_frame_class2_errors   (rsp_frame_class2_errors),
      .rsp_measuring             (rsp_measuring),
      .rsp_report_ready          (rsp_report_ready),
      .rsp_report_frame_errors   (rsp_report_frame_errors),
      .rsp_report_class1b_errors (rsp_report_class1b_errors),
      .rsp_report_class2_errors  (rsp_report_class2_errors),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int sat_add(input int a, input int b, input int max);
      int s;
      s = a + b;
      return (s > max) ? max : s;
   endfunction

   function automatic void reset_model();
      cfg_lost_1a = RST_LOST_1A;
      cfg_lost_1b = RST_LOST_1B;
      cfg_lost_2 = RST_LOST_2;
      cfg_min_ones = RST_MIN_ONES;
      cfg_report_len = RST_REPORT_LEN;
      frame_err_1a = '0;
      frame_err_1b = '0;
      frame_err_2 = '0;
      frame_ones = '0;
      measuring_mode = 1'b0;
      window_count = '0;
      win_frame_errors = '0;
      win_err_1b = '0;
      win_err_2 = '0;
   endfunction

   function automatic void count_word(input logic func, input logic rx, input logic expb,
                                      input logic [CLASS_W-1:0] cls, input logic end_bit);
      frame_result_type res;
      int               bit_err;
      res = '{default: '0};
      bit_err = int'(rx ^ expb);
      if (!func) begin
         if (cls != CLASS_NONE) begin
            case (cls)
               CLASS_1A: frame_err_1a = CNT_W'(sat_add(int'(frame_err_1a), bit_err, MAX_CNT));
               CLASS_1B: frame_err_1b = CNT_W'(sat_add(int'(frame_err_1b), bit_err, MAX_CNT));
               default:  frame_err_2 = CNT_W'(sat_add(int'(frame_err_2), bit_err, MAX_CNT));
            endcase
            frame_ones = CNT_W'(sat_add(int'(frame_ones), int'(rx), MAX_CNT));
         end
         if (!end_bit) return;
         res.err_1a = frame_err_1a;
         res.err_1b = frame_err_1b;
         res.err_2 = frame_err_2;
         res.frame_ignored = (frame_ones < cfg_min_ones);
         frame_err_1a = '0;
         frame_err_1b = '0;
         frame_err_2 = '0;
         frame_ones = '0;
      end else begin
         res.err_1a = cfg_lost_1a >> 1;
         res.err_1b = cfg_lost_1b >> 1;
         res.err_2 = cfg_lost_2 >> 1;
      end
      if (!res.frame_ignored && measuring_mode) begin
         if (res.err_1a != '0)
            win_frame_errors = WIN_W'(sat_add(int'(win_frame_errors), 1, MAX_WIN));
         win_err_1b = ACC_W'(sat_add(int'(win_err_1b), int'(res.err_1b), MAX_ACC));
         win_err_2 = ACC_W'(sat_add(int'(win_err_2), int'(res.err_2), MAX_ACC));
         window_count = window_count + WIN_W'(1);
         if (window_count == cfg_report_len) begin
            res.report_ready = 1'b1;
            res.report_frame_errors = win_frame_errors;
            res.report_1b = win_err_1b;
            res.report_2 = win_err_2;
            win_frame_errors = '0;
            win_err_1b = '0;
            win_err_2 = '0;
            window_count = '0;
         end
      end
      if (!func && !res.frame_ignored && res.err_1a == '0) measuring_mode = 1'b1;
      res.frame_bad = res.frame_ignored || (res.err_1a != '0);
      res.measuring = measuring_mode;
      expected_frames_q.push_back(res);
   endfunction

   task automatic send_word(input logic func, input logic rx, input logic expb,
                            input logic [CLASS_W-1:0] cls, input logic end_bit);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_rx_bit <= rx;
      req_ref_bit <= expb;
      req_bit_class <= cls;
      req_last_bit <= end_bit;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      count_word(func, rx, expb, cls, end_bit);
   endtask

   task automatic send_lost();
      send_word(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                CLASS_W'($urandom_range(3)), 1'($urandom_range(1)));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_LOST_1A:    cfg_lost_1a = data[CNT_W-1:0];
         REG_LOST_1B:    cfg_lost_1b = data[CNT_W-1:0];
         REG_LOST_2:     cfg_lost_2 = data[CNT_W-1:0];
         REG_MIN_ONES:   cfg_min_ones = data[CNT_W-1:0];
         REG_REPORT_LEN: cfg_report_len = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_frame_result();
      frame_result_type want;
      if (expected_frames_q.size() == 0) begin
         $display("%0t: frame result word with none expected", $time);
         error_count++;
         return;
      end
      want = expected_frames_q.pop_front();
      check_field("frame_bad", 32'(want.frame_bad), 32'(rsp_frame_bad));
      check_field("frame_ignored", 32'(want.frame_ignored), 32'(rsp_frame_ignored));
      check_field("frame_class1a_errors", 32'(want.err_1a), 32'(rsp_frame_class1a_errors));
      check_field("frame_class1b_errors", 32'(want.err_1b), 32'(rsp_frame_class1b_errors));
      check_field("frame_class2_errors", 32'(want.err_2), 32'(rsp_frame_class2_errors));
      check_field("measuring", 32'(want.measuring), 32'(rsp_measuring));
      check_field("report_ready", 32'(want.report_ready), 32'(rsp_report_ready));
      check_field("report_frame_errors", 32'(want.report_frame_errors),
                  32'(rsp_report_frame_errors));
      check_field("report_class1b_errors", 32'(want.report_1b),
                  32'(rsp_report_class1b_errors));
      check_field("report_class2_errors", 32'(want.report_2),
                  32'(rsp_report_class2_errors));
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_frame_result();
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic logic [CSR_DAT_W-1:0] pick_lost_total();
      case ($urandom_range(5))
         0:       return {1'($urandom_range(1)), CNT_W'(0)};
         1:       return {1'($urandom_range(1)), CNT_W'(MAX_CNT)};
         2:       return CSR_DAT_W'(1);
         default: return CSR_DAT_W'($urandom_range(MAX_WIN));
      endcase
   endfunction

   task automatic set_random_config();
      logic [CSR_DAT_W-1:0] min_ones_val, len_val;
      case ($urandom_range(7))
         0:       min_ones_val = {1'($urandom_range(1)), CNT_W'(0)};
         1:       min_ones_val = {1'($urandom_range(1)), CNT_W'(MAX_CNT)};
         default: min_ones_val = CSR_DAT_W'($urandom_range(6));
      endcase
      case ($urandom_range(7))
         0:       len_val = '0;
         1:       len_val = CSR_DAT_W'(MAX_WIN);
         2:       len_val = CSR_DAT_W'(1);
         default: len_val = CSR_DAT_W'($urandom_range(2, 6));
      endcase
      write_reg(REG_LOST_1A, pick_lost_total());
      write_reg(REG_LOST_1B, pick_lost_total());
      write_reg(REG_LOST_2, pick_lost_total());
      write_reg(REG_MIN_ONES, min_ones_val);
      write_reg(REG_REPORT_LEN, len_val);
      if ($urandom_range(3) == 0)
         write_reg(CSR_IDX_W'(REG_REPORT_LEN + 1 + $urandom_range(2)),
                   CSR_DAT_W'($urandom_range(MAX_WIN)));
   endtask

   task automatic send_random_frame();
      int nbits, err_pct;
      logic rx;
      if ($urandom_range(11) == 0) begin
         send_lost();
         return;
      end
      nbits = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      err_pct = $urandom_range(1) ? 0 : $urandom_range(40);
      for (int i = 0; i < nbits; i++) begin
         if ($urandom_range(24) == 0) send_lost();
         rx = 1'($urandom_range(1));
         send_word(1'b0, rx, rx ^ ($urandom_range(99) < err_pct),
                   CLASS_W'($urandom_range(3)), i == nbits - 1);
      end
   endtask

   task automatic test_directed();
      send_word(1'b1, 1'b1, 1'b1, CLASS_NONE, 1'b1);
      send_word(1'b0, 1'b1, 1'b1, CLASS_1A, 1'b0);
      send_word(1'b0, 1'b0, 1'b1, CLASS_1B, 1'b0);
      send_word(1'b0, 1'b1, 1'b0, CLASS_2, 1'b0);
      send_word(1'b0, 1'b1, 1'b0, CLASS_NONE, 1'b1);
      wait_idle();
      write_reg(REG_MIN_ONES, CSR_DAT_W'(2));
      write_reg(REG_REPORT_LEN, CSR_DAT_W'(2));
      send_word(1'b0, 1'b1, 1'b1, CLASS_1A, 1'b0);
      send_word(1'b0, 1'b1, 1'b1, CLASS_1B, 1'b0);
      send_word(1'b0, 1'b0, 1'b0, CLASS_2, 1'b1);
      send_word(1'b0, 1'b1, 1'b0, CLASS_1A, 1'b0);
      send_word(1'b0, 1'b1, 1'b1, CLASS_NONE, 1'b1);
      send_word(1'b0, 1'b1, 1'b1, CLASS_1B, 1'b0);
      send_word(1'b0, 1'b0, 1'b1, CLASS_1A, 1'b0);
      send_word(1'b1, 1'b0, 1'b0, CLASS_1A, 1'b0);
      send_word(1'b0, 1'b1, 1'b1, CLASS_2, 1'b1);
      send_word(1'b0, 1'b0, 1'b0, CLASS_1A, 1'b0);
      send_word(1'b0, 1'b1, 1'b1, CLASS_1A, 1'b1);
      wait_idle();
   endtask

   task automatic test_frame_saturation();
      write_reg(REG_MIN_ONES, CSR_DAT_W'(MAX_CNT));
      for (int i = 0; i < SAT_FRAME_BITS; i++) begin
         send_word(1'b0, 1'b1, 1'b0, CLASS_1A, i == SAT_FRAME_BITS - 1);
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      int start;
      write_reg(REG_MIN_ONES, '0);
      write_reg(REG_REPORT_LEN, CSR_DAT_W'(3));
      start = words_sent;
      no_idle = 1'b1;
      hold_off_req = 1'b1;
      while (words_sent - start < 200) send_random_frame();
      no_idle = 1'b0;
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int start, phase_start;
      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         set_random_config();
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) send_random_frame();
         wait_idle();
      end
   endtask

   initial begin
      reset_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_frame_saturation();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule
